// ===== rtl/core/frwm_pkg.sv =====
// Shared types, constants and width helpers of the frame rate window meter.
package frwm_pkg;

  // Fixed field widths
  localparam int TS_W        = 32;
  localparam int FPS_W       = 22;
  localparam int FILLED_W    = 4;

  // Defaults and arithmetic constants
  localparam int WINDOW_DEF  = 10;
  localparam int MS_PER_S_Q8 = 256000;    // 1000 ms in Q8
  localparam int MS_Q8_W     = 18;        // bits that hold MS_PER_S_Q8
  localparam int FPS_MAX     = 4194303;   // 2^22 - 1

  // Width helpers, all derived from the window depth
  function automatic int fill_w(input int window);
    return $clog2(window + 1);
  endfunction

  function automatic int slot_w(input int window);
    return (window > 1) ? $clog2(window) : 1;
  endfunction

  function automatic int sum_w(input int window);
    return TS_W + $clog2(window + 1);
  endfunction

  function automatic int num_w(input int window);
    return MS_Q8_W + fill_w(window);
  endfunction

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } frwm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept_restart;
    logic accept_frame;
    logic update;
    logic div_load;
    logic div_step;
    logic out_load;
  } frwm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_zero;
    logic out_free;
  } frwm_sts_t;

endpackage

// ===== rtl/core/frwm_in_if.sv =====
// Input channel: one beat per event with kind and millisecond timestamp.
interface frwm_in_if;
  import frwm_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [TS_W-1:0] timestamp_ms;

  modport source (output valid, output kind, output timestamp_ms, input ready);
  modport sink   (input valid, input kind, input timestamp_ms, output ready);
endinterface

// ===== rtl/core/frwm_out_if.sv =====
// Result channel: one beat per finished frame with the windowed rate.
interface frwm_out_if;
  import frwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [FPS_W-1:0]    fps_q8;
  logic                zero_time_flag;
  logic [FILLED_W-1:0] window_filled;

  modport source (output valid, output fps_q8, output zero_time_flag,
                  output window_filled, input ready);
  modport sink   (input valid, input fps_q8, input zero_time_flag,
                  input window_filled, output ready);
endinterface

// ===== rtl/core/frwm_ctrl.sv =====
// Controller state machine: sequences ring update, division and result load.
module frwm_ctrl
  import frwm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  input  frwm_sts_t sts,
  output frwm_cmd_t cmd
);

  localparam int NUM_W = num_w(WINDOW);
  localparam int CNT_W = $clog2(NUM_W + 1);

  frwm_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  // State and bit counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  // Bit counter: one quotient bit per divide step
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    if (cmd.div_load) begin
      bit_cnt_nxt = CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt = sts.sum_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt_r == CNT_W'(1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs; no beat is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready           = rst_n;
        cmd.accept_frame   = rst_n && in_valid && in_kind;
        cmd.accept_restart = rst_n && in_valid && !in_kind;
      end
      ST_UPDATE: cmd.update   = 1'b1;
      ST_LOAD:   cmd.div_load = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_DONE:   cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/frwm_datapath.sv =====
// Datapath: delta ring memory, running sum, restoring divider, output register.
module frwm_datapath
  import frwm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  frwm_cmd_t           cmd,
  output frwm_sts_t           sts,
  input  logic [TS_W-1:0]     in_timestamp_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FPS_W-1:0]    out_fps_q8,
  output logic                out_zero_time_flag,
  output logic [FILLED_W-1:0] out_window_filled
);

  localparam int FILL_W = fill_w(WINDOW);
  localparam int SLOT_W = slot_w(WINDOW);
  localparam int SUM_W  = sum_w(WINDOW);
  localparam int NUM_W  = num_w(WINDOW);
  localparam int QX_W   = NUM_W + FPS_W;

  logic [TS_W-1:0]     last_time_r;
  logic [TS_W-1:0]     delta_r;
  logic [TS_W-1:0]     old_delta_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [FILL_W-1:0]   fill_r;
  logic [SUM_W-1:0]    sum_r;
  logic [TS_W-1:0]     ring_mem [WINDOW];

  logic [NUM_W-1:0]    num_r;
  logic [NUM_W-1:0]    quo_r;
  logic [SUM_W-1:0]    rem_r;

  logic                out_valid_r;
  logic [FPS_W-1:0]    fps_r;
  logic                flag_r;
  logic [FILLED_W-1:0] filled_r;

  logic                ring_full;
  logic [SLOT_W-1:0]   slot_inc;
  logic [SUM_W-1:0]    sum_nxt;
  logic [NUM_W-1:0]    num_init;
  logic [SUM_W:0]      rem_shift;
  logic                rem_ge;
  logic [QX_W-1:0]     quo_ext;
  logic [FPS_W-1:0]    fps_sat;
  logic [FILL_W+FILLED_W-1:0] fill_ext;

  assign ring_full = (fill_r == FILL_W'(WINDOW));
  assign slot_inc  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);

  // Running sum: drop the oldest delta once the window is full
  assign sum_nxt = sum_r + SUM_W'(delta_r) - (ring_full ? SUM_W'(old_delta_r) : '0);

  // Ring memory: read the slot at accept, overwrite it in the update step
  always_ff @(posedge clk) begin
    if (cmd.accept_frame) old_delta_r <= ring_mem[slot_r];
    if (cmd.update)       ring_mem[slot_r] <= delta_r;
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (cmd.accept_restart) begin
        last_time_r <= in_timestamp_ms;
        slot_r      <= '0;
        fill_r      <= '0;
        sum_r       <= '0;
      end else if (cmd.accept_frame) begin
        last_time_r <= in_timestamp_ms;
      end else if (cmd.update) begin
        sum_r  <= sum_nxt;
        slot_r <= slot_inc;
        if (!ring_full) fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  // Frame delta, modulo 2^32
  always_ff @(posedge clk) begin
    if (cmd.accept_frame) delta_r <= in_timestamp_ms - last_time_r;
  end

  // Restoring divider: 256000 * fill / sum, one quotient bit per step
  assign num_init  = NUM_W'(MS_PER_S_Q8) * NUM_W'(fill_r);
  assign rem_shift = {rem_r, num_r[NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, sum_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r <= num_init;
      quo_r <= '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? SUM_W'(rem_shift - {1'b0, sum_r}) : rem_shift[SUM_W-1:0];
    end
  end

  // Saturate the quotient to the result field
  assign quo_ext  = {{FPS_W{1'b0}}, quo_r};
  assign fps_sat  = (quo_ext > QX_W'(FPS_MAX)) ? FPS_W'(FPS_MAX) : quo_ext[FPS_W-1:0];
  assign fill_ext = {{FILLED_W{1'b0}}, fill_r};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fps_r    <= fps_sat;
      flag_r   <= (sum_r == '0);
      filled_r <= fill_ext[FILLED_W-1:0];
    end
  end

  assign sts.sum_zero      = (sum_r == '0);
  assign sts.out_free      = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_fps_q8         = fps_r;
  assign out_zero_time_flag = flag_r;
  assign out_window_filled  = filled_r;

endmodule

// ===== rtl/core/frame_rate_window_meter_top.sv =====
// Top level of the moving-average frame rate meter.
//
//   channel   dir  beat payload                               handshake
//   in_chan   in   kind, timestamp_ms                         valid/ready
//   out_chan  out  fps_q8, zero_time_flag, window_filled      valid/ready
//
// A frame beat holds the block from its accept cycle through its result load
// cycle, stepping through the ring update, the divider load, the restoring
// divider (one quotient bit per cycle) and the result load; a zero sum skips
// the division. A restart beat gives no result. Reset (rst_n low, synchronous)
// clears the window and holds in_ready low; the ring memory is not cleared,
// only written entries are used. A stalled result holds in the output
// register while new beats are still taken; the next frame then waits after
// its division until the register is free.
module frame_rate_window_meter_top
  import frwm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  frwm_in_if.sink    in_chan,
  frwm_out_if.source out_chan
);

  frwm_cmd_t cmd;
  frwm_sts_t sts;

  // Sequencer
  frwm_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window state, divider and output register
  frwm_datapath #(.WINDOW(WINDOW)) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_timestamp_ms    (in_chan.timestamp_ms),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_fps_q8         (out_chan.fps_q8),
    .out_zero_time_flag (out_chan.zero_time_flag),
    .out_window_filled  (out_chan.window_filled)
  );

  // An accepted frame beat is followed by the ring update
  a_frame_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.kind) |=> cmd.update)
    else $error("ring update did not follow a frame beat");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // A loaded result is offered on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_chan.valid)
    else $error("loaded result not offered");

  // No input is taken while the divider runs
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.div_load) |-> !in_chan.ready)
    else $error("input taken during division");

endmodule
